// ----- sv/nsd_pkg.sv -----
// nsd_pkg: types, codes and constants for the Netpbm stream decoder.
// Used by netpbm_stream_decoder; no dependencies.
package nsd_pkg;

  // Largest width/height exponent accepted
  localparam int DIM_BITS = 16;
  localparam logic [15:0] DIM_LIMIT =
    (DIM_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << DIM_BITS) - 32'd1);

  // Result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_HEADER = 2'd1;
  localparam logic [1:0] ERR_TRUNC  = 2'd2;
  localparam logic [1:0] ERR_DIM    = 2'd3;

  // Characters
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SIX   = 8'h36;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_SPACE = 8'd32;

  // Parser phase
  typedef enum logic [6:0] {
    PH_MAGIC_P   = 7'b0000001,
    PH_MAGIC_NUM = 7'b0000010,
    PH_WIDTH     = 7'b0000100,
    PH_HEIGHT    = 7'b0001000,
    PH_MAXVAL    = 7'b0010000,
    PH_DATA      = 7'b0100000,
    PH_DONE      = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  error_code;
    logic [15:0] pixel_row;
    logic [15:0] pixel_col;
    logic [15:0] red_or_gray;
    logic [15:0] green_sample;
    logic [15:0] blue_sample;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        wide_samples;
    logic        is_color;
    logic        last_of_run;
  } res_t;

  // Parser state
  typedef struct packed {
    phase_t      phase;
    logic [2:0]  fmt;
    logic [15:0] width;
    logic [15:0] height;
    logic [15:0] maxs;
    logic [15:0] accum;
    logic        ovf;
    logic        token;
    logic        in_comment;
    logic [15:0] row;
    logic [15:0] col;
    logic [1:0]  chan;
    logic        hbp;
    logic [7:0]  hhb;
    logic [15:0] red;
    logic [15:0] green;
    logic        err;
  } st_t;

  localparam st_t ST_RESET = '{
    phase: PH_MAGIC_P, fmt: 3'd0, width: 16'd0, height: 16'd0,
    maxs: 16'd255, accum: 16'd0, ovf: 1'b0, token: 1'b0,
    in_comment: 1'b0, row: 16'd0, col: 16'd0, chan: 2'd0, hbp: 1'b0,
    hhb: 8'd0, red: 16'd0, green: 16'd0, err: 1'b0};

  // State plus the short result list built while decoding one byte
  typedef struct packed {
    st_t        st;
    res_t [1:0] gen;
    logic [1:0] gcnt;
  } work_t;

endpackage

// ----- sv/netpbm_stream_decoder.sv -----
// Netpbm stream decoder: a transferred byte waits in the input register, then
// is decoded into the result registers. One byte per cycle while out_ready
// holds and each byte gives at most one result; a byte with several results
// (P4 bursts up to 8 pixels, plus an error) holds input until its last result
// is taken at the single result port. rst (synchronous) returns the parser to
// awaiting the magic letter and empties the input and result registers.
module netpbm_stream_decoder
  import nsd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  // Input register
  logic in_full;
  in_t  in_q;

  // Parser state
  st_t st;
  st_t st_next;

  // Result bundle of the byte being delivered
  logic [7:0]  p4_bits;
  logic [3:0]  p4_n;
  logic [3:0]  p4_idx;
  logic [15:0] p4_row;
  logic [15:0] p4_col;
  res_t [1:0]  gen;
  logic [1:0]  gen_n;
  logic [1:0]  gen_idx;

  logic [7:0]  p4_bits_next;
  logic [3:0]  p4_n_next;
  logic [15:0] p4_row_next;
  logic [15:0] p4_col_next;
  res_t [1:0]  gen_next;
  logic [1:0]  gen_n_next;

  logic p4_act, is_last, can_load, proc;

  function automatic logic f_space(logic [7:0] b);
    return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic logic f_color(logic [2:0] fmt);
    return (fmt == 3'd3) || (fmt == 3'd6);
  endfunction

  function automatic work_t f_emit(work_t w, res_t r);
    if (w.gcnt < 2'd2) begin
      w.gen[w.gcnt[0]] = r;
      w.gcnt = w.gcnt + 2'd1;
    end
    return w;
  endfunction

  function automatic work_t f_fail(work_t w, logic [1:0] code);
    res_t r;
    r = '0;
    r.kind = KIND_ERROR;
    r.error_code = code;
    w = f_emit(w, r);
    w.st.err = 1'b1;
    w.st.phase = PH_DONE;
    w.st.in_comment = 1'b0;
    w.st.token = 1'b0;
    return w;
  endfunction

  function automatic work_t f_put(work_t w, logic [15:0] rv, logic [15:0] gv,
                                  logic [15:0] bv);
    res_t r;
    r = '0;
    r.kind = KIND_PIXEL;
    r.pixel_row = w.st.row;
    r.pixel_col = w.st.col;
    r.red_or_gray = rv;
    r.green_sample = gv;
    r.blue_sample = bv;
    w = f_emit(w, r);
    w.st.col = w.st.col + 16'd1;
    if (w.st.col >= w.st.width) begin
      w.st.col = 16'd0;
      w.st.row = w.st.row + 16'd1;
      if (w.st.row >= w.st.height) w.st.phase = PH_DONE;
    end
    return w;
  endfunction

  function automatic work_t f_push(work_t w, logic [15:0] s);
    if (f_color(w.st.fmt)) begin
      if (w.st.chan == 2'd0) begin
        w.st.red = s;
        w.st.chan = 2'd1;
      end else if (w.st.chan == 2'd1) begin
        w.st.green = s;
        w.st.chan = 2'd2;
      end else begin
        w.st.chan = 2'd0;
        w = f_put(w, w.st.red, w.st.green, s);
      end
    end else begin
      w = f_put(w, s, 16'd0, 16'd0);
    end
    return w;
  endfunction

  function automatic work_t f_start(work_t w);
    res_t r;
    r = '0;
    w.st.phase = PH_DATA;
    w.st.row = 16'd0;
    w.st.col = 16'd0;
    w.st.chan = 2'd0;
    w.st.hbp = 1'b0;
    r.kind = KIND_HEADER;
    r.image_width = w.st.width;
    r.image_height = w.st.height;
    r.wide_samples = (w.st.maxs > 16'd255);
    r.is_color = f_color(w.st.fmt);
    return f_emit(w, r);
  endfunction

  function automatic work_t f_hdr_done(work_t w, logic has_term, logic [7:0] term);
    if (w.st.fmt >= 3'd4 && has_term && !f_space(term)) w = f_fail(w, ERR_HEADER);
    else w = f_start(w);
    return w;
  endfunction

  function automatic work_t f_finish(work_t w, logic has_term, logic [7:0] term);
    logic [15:0] v;
    logic        o;
    logic [15:0] s;
    v = w.st.accum;
    o = w.st.ovf;
    w.st.accum = 16'd0;
    w.st.ovf = 1'b0;
    w.st.token = 1'b0;
    case (w.st.phase)
      PH_WIDTH: begin
        if (o || v > DIM_LIMIT) w = f_fail(w, ERR_DIM);
        else if (v == 16'd0) w = f_fail(w, ERR_HEADER);
        else begin
          w.st.width = v;
          w.st.phase = PH_HEIGHT;
        end
      end
      PH_HEIGHT: begin
        if (o || v > DIM_LIMIT) w = f_fail(w, ERR_DIM);
        else if (v == 16'd0) w = f_fail(w, ERR_HEADER);
        else begin
          w.st.height = v;
          if (w.st.fmt == 3'd1 || w.st.fmt == 3'd4) begin
            w.st.maxs = 16'd1;
            w = f_hdr_done(w, has_term, term);
          end else begin
            w.st.phase = PH_MAXVAL;
          end
        end
      end
      PH_MAXVAL: begin
        if (o || v == 16'd0) w = f_fail(w, ERR_HEADER);
        else begin
          w.st.maxs = v;
          w = f_hdr_done(w, has_term, term);
        end
      end
      PH_DATA: begin
        s = o ? 16'hFFFF : v;
        if (w.st.maxs <= 16'd255 && s > 16'd255) s = 16'd255;
        w = f_push(w, s);
      end
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic f_text_phase(st_t s);
    if (s.err) return 1'b0;
    if (s.phase == PH_WIDTH || s.phase == PH_HEIGHT || s.phase == PH_MAXVAL)
      return 1'b1;
    return (s.phase == PH_DATA) && (s.fmt <= 3'd3);
  endfunction

  function automatic work_t f_text(work_t w, logic [7:0] b);
    logic [19:0] t;
    if (w.st.in_comment) begin
      if (b == CH_LF || b == CH_CR) w.st.in_comment = 1'b0;
    end else if (b >= CH_ZERO && b <= CH_NINE) begin
      if (w.st.phase == PH_DATA && w.st.fmt == 3'd1) begin
        w = f_put(w, (b == CH_ZERO) ? 16'd255 : 16'd0, 16'd0, 16'd0);
      end else begin
        t = 20'(w.st.accum) * 20'd10 + 20'(b - CH_ZERO);
        if (w.st.ovf || t > 20'hFFFF) begin
          w.st.ovf = 1'b1;
          w.st.accum = 16'hFFFF;
        end else begin
          w.st.accum = t[15:0];
        end
        w.st.token = 1'b1;
      end
    end else begin
      if (w.st.token) w = f_finish(w, 1'b1, b);
      if (f_text_phase(w.st) && !f_space(b)) begin
        if (b == CH_HASH) w.st.in_comment = 1'b1;
        else w = f_fail(w, (w.st.phase == PH_DATA) ? ERR_TRUNC : ERR_HEADER);
      end
    end
    return w;
  endfunction

  // Decode one byte: next state and its results
  always_comb begin
    work_t       w;
    logic [7:0]  b;
    logic [15:0] rem;
    logic [3:0]  n4;
    b = in_q.data_byte;
    w.st = st;
    w.gen = '0;
    w.gcnt = 2'd0;
    rem = st.width - st.col;
    n4 = (rem > 16'd8) ? 4'd8 : rem[3:0];
    p4_bits_next = b;
    p4_n_next = 4'd0;
    p4_row_next = st.row;
    p4_col_next = st.col;
    if (!st.err) begin
      case (st.phase)
        PH_MAGIC_P: begin
          if (b == CH_P) w.st.phase = PH_MAGIC_NUM;
          else w = f_fail(w, ERR_HEADER);
        end
        PH_MAGIC_NUM: begin
          if (b >= CH_ONE && b <= CH_SIX) begin
            w.st.fmt = 3'(b - CH_ZERO);
            w.st.phase = PH_WIDTH;
          end else begin
            w = f_fail(w, ERR_HEADER);
          end
        end
        PH_DATA: begin
          if (st.fmt == 3'd4) begin
            // packed bits, all in one row
            p4_n_next = n4;
            if (16'(n4) == rem) begin
              w.st.col = 16'd0;
              w.st.row = st.row + 16'd1;
              if (w.st.row >= st.height) w.st.phase = PH_DONE;
            end else begin
              w.st.col = st.col + 16'(n4);
            end
          end else if (st.fmt >= 3'd5) begin
            if (st.maxs <= 16'd255) w = f_push(w, 16'(b));
            else if (!st.hbp) begin
              w.st.hhb = b;
              w.st.hbp = 1'b1;
            end else begin
              w.st.hbp = 1'b0;
              w = f_push(w, {st.hhb, b});
            end
          end else begin
            w = f_text(w, b);
          end
        end
        PH_DONE: ;
        default: w = f_text(w, b);
      endcase
    end
    // End of file: flush pending number, report missing parts, restart
    if (in_q.end_of_input) begin
      if (!w.st.err && w.st.token) w = f_finish(w, 1'b0, 8'd0);
      if (!w.st.err) begin
        if (w.st.phase == PH_MAGIC_P || w.st.phase == PH_MAGIC_NUM ||
            w.st.phase == PH_WIDTH || w.st.phase == PH_HEIGHT ||
            w.st.phase == PH_MAXVAL)
          w = f_fail(w, ERR_HEADER);
        else if (w.st.phase == PH_DATA)
          w = f_fail(w, ERR_TRUNC);
      end
      w.st = ST_RESET;
    end
    st_next = w.st;
    gen_next = w.gen;
    gen_n_next = w.gcnt;
  end

  // Result sequencing: packed-bit pixels first, then the short list
  assign p4_act = (p4_idx < p4_n);
  assign out_valid = p4_act || (gen_idx < gen_n);
  assign is_last = p4_act ? ((p4_idx == p4_n - 4'd1) && (gen_n == 2'd0))
                          : (gen_idx == gen_n - 2'd1);
  assign can_load = !out_valid || (out_ready && is_last);
  assign proc = in_full && can_load;
  assign in_ready = !in_full || proc;

  always_comb begin
    if (p4_act) begin
      out_data = '0;
      out_data.kind = KIND_PIXEL;
      out_data.pixel_row = p4_row;
      out_data.pixel_col = p4_col + 16'(p4_idx);
      out_data.red_or_gray = p4_bits[3'd7 - p4_idx[2:0]] ? 16'd0 : 16'd255;
    end else begin
      out_data = gen[gen_idx[0]];
    end
    out_data.last_of_run = is_last;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
      st <= ST_RESET;
      p4_n <= 4'd0;
      p4_idx <= 4'd0;
      gen_n <= 2'd0;
      gen_idx <= 2'd0;
    end else begin
      if (in_valid && in_ready) in_full <= 1'b1;
      else if (proc) in_full <= 1'b0;
      if (proc) begin
        st <= st_next;
        p4_n <= p4_n_next;
        p4_idx <= 4'd0;
        gen_n <= gen_n_next;
        gen_idx <= 2'd0;
      end else if (out_valid && out_ready) begin
        if (p4_act) p4_idx <= p4_idx + 4'd1;
        else gen_idx <= gen_idx + 2'd1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_q <= in_data;
    if (proc) begin
      p4_bits <= p4_bits_next;
      p4_row <= p4_row_next;
      p4_col <= p4_col_next;
      gen <= gen_next;
    end
  end

  // Checks
  a_bundle_bound: assert property (@(posedge clk) disable iff (rst)
    (p4_n <= 4'd8) && (gen_n <= 2'd2))
    else $error("result bundle count out of range");

  a_error_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.kind == KIND_ERROR) |-> out_data.last_of_run)
    else $error("error result is not the final result of its byte");

  a_header_dims: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.kind == KIND_HEADER) |->
      (out_data.image_width != 16'd0 && out_data.image_height != 16'd0))
    else $error("header result with zero size");

  a_load_clears: assert property (@(posedge clk) disable iff (rst)
    proc |=> (p4_idx == 4'd0 && gen_idx == 2'd0))
    else $error("result cursor not reset on load");

endmodule
